[design/szcf_pkg.sv]
// Package with the word types, configuration codes and control structs of the zero-crossing finder.
package szcf_pkg;

  localparam int DATA_W = 32;
  localparam int EPS_W = 31;
  localparam int BUDGET_W = 10;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_EPSILON = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUDGET = 1'd1;

  localparam logic [EPS_W-1:0] EPSILON_RESET = 31'd17;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 10'd100;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_x;
    logic signed [DATA_W-1:0] sample_f;
    logic                     last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] zero_first;
    logic signed [DATA_W-1:0] zero_second;
    logic                     both_found;
  } result_t;

  typedef struct packed {
    logic load;
    logic start_ref;
    logic mid;
    logic span;
    logic mul;
    logic cmp;
    logic fin_plain;
    logic fin_cross;
  } szcf_cmd_t;

  typedef struct packed {
    logic refine;
    logic keep_going;
    logic emit_plain;
    logic emit_cross;
    logic out_free;
  } szcf_status_t;

endpackage

[design/szcf_ctrl.sv]
// Controller state machine that sequences sample intake and the bisection steps.
module szcf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  szcf_pkg::szcf_status_t status,
  output szcf_pkg::szcf_cmd_t  cmd
);
  import szcf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_MID   = 3'd3;
  localparam logic [2:0] S_DIST  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_CROSS = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign sample_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.refine) begin
          cmd.start_ref = 1'b1;
          state_next = S_CHK;
        end else if (!status.emit_plain || status.out_free) begin
          cmd.fin_plain = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHK: begin
        state_next = status.keep_going ? S_MID : S_CROSS;
      end
      S_MID: begin
        cmd.mid = 1'b1;
        state_next = S_DIST;
      end
      S_DIST: begin
        cmd.span = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        state_next = S_CHK;
      end
      S_CROSS: begin
        if (!status.emit_cross || status.out_free) begin
          cmd.fin_cross = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/szcf_datapath.sv]
// Datapath with set state, bisection registers, configuration registers and the result register.
module szcf_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  szcf_pkg::sample_t     sample,
  input  logic                  cfg_valid,
  input  logic [szcf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [szcf_pkg::DATA_W-1:0]      cfg_data,
  input  szcf_pkg::szcf_cmd_t   cmd,
  output szcf_pkg::szcf_status_t status,
  output logic                  result_valid,
  input  logic                  result_stall,
  output szcf_pkg::result_t     result
);
  import szcf_pkg::*;

  logic [EPS_W-1:0]         epsilon;
  logic [BUDGET_W-1:0]      iteration_budget;

  logic signed [DATA_W-1:0] cur_x;
  logic signed [DATA_W-1:0] cur_f;
  logic                     cur_last;

  logic signed [DATA_W-1:0] previous_x;
  logic signed [DATA_W-1:0] previous_f;
  logic                     have_previous;
  logic signed [DATA_W-1:0] first_crossing;
  logic                     first_found;
  logic [BUDGET_W-1:0]      steps_used;
  logic                     set_done;

  logic signed [DATA_W-1:0] lo_end;
  logic signed [DATA_W-1:0] hi_end;
  logic signed [DATA_W-1:0] mid;
  logic [DATA_W-1:0]        mag_left;
  logic [DATA_W-1:0]        mag_right;
  logic [DATA_W-1:0]        dist_left;
  logic [DATA_W-1:0]        dist_right;
  logic [2*DATA_W-1:0]      prod_left;
  logic [2*DATA_W-1:0]      prod_right;

  logic                     sign_change;
  logic [DATA_W-1:0]        width;
  logic [DATA_W:0]          mid_sum;
  logic                     emit;
  result_t                  emit_word;

  assign sign_change = (previous_f[DATA_W-1] && !cur_f[DATA_W-1] && (cur_f != '0)) ||
                       (!previous_f[DATA_W-1] && (previous_f != '0) && cur_f[DATA_W-1]);

  assign width = (hi_end >= lo_end) ? $unsigned(hi_end - lo_end)
                                    : $unsigned(lo_end - hi_end);
  assign mid_sum = {lo_end[DATA_W-1], lo_end} + {hi_end[DATA_W-1], hi_end};

  assign status.refine     = !set_done && have_previous && sign_change;
  assign status.keep_going = (width > {1'b0, epsilon}) && (steps_used < iteration_budget);
  assign status.emit_plain = cur_last && !set_done;
  assign status.emit_cross = first_found || cur_last;
  assign status.out_free   = !result_valid || !result_stall;

  always_comb begin
    emit = 1'b0;
    emit_word = '0;
    if (cmd.fin_plain && status.emit_plain) begin
      emit = 1'b1;
    end else if (cmd.fin_cross && status.emit_cross) begin
      emit = 1'b1;
      if (first_found) begin
        emit_word.zero_first  = first_crossing;
        emit_word.zero_second = mid;
        emit_word.both_found  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPSILON_RESET;
      iteration_budget <= BUDGET_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EPSILON: epsilon <= cfg_data[EPS_W-1:0];
        REG_BUDGET: iteration_budget <= cfg_data[BUDGET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= sample.sample_x;
      cur_f <= sample.sample_f;
      cur_last <= sample.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_ref) begin
      lo_end <= previous_x;
      hi_end <= cur_x;
      mid <= previous_x;
      mag_left <= previous_f[DATA_W-1] ? $unsigned(-previous_f) : $unsigned(previous_f);
      mag_right <= cur_f[DATA_W-1] ? $unsigned(-cur_f) : $unsigned(cur_f);
    end
    if (cmd.mid) begin
      mid <= $signed(mid_sum[DATA_W:1]);
    end
    if (cmd.span) begin
      dist_left <= (cur_x >= mid) ? $unsigned(cur_x - mid) : $unsigned(mid - cur_x);
      dist_right <= (mid >= previous_x) ? $unsigned(mid - previous_x)
                                        : $unsigned(previous_x - mid);
    end
    if (cmd.mul) begin
      prod_left <= mag_left * dist_left;
      prod_right <= mag_right * dist_right;
    end
    if (cmd.cmp) begin
      if (prod_right > prod_left) begin
        hi_end <= mid;
      end else begin
        lo_end <= mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_plain && !cur_last && !set_done) begin
      previous_x <= cur_x;
      previous_f <= cur_f;
    end
    if (cmd.fin_cross && !cur_last) begin
      previous_x <= cur_x;
      previous_f <= cur_f;
      if (!first_found) begin
        first_crossing <= mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      first_found <= 1'b0;
      steps_used <= '0;
      set_done <= 1'b0;
    end else begin
      if (cmd.mid) begin
        steps_used <= steps_used + 1'b1;
      end
      if ((cmd.fin_plain || cmd.fin_cross) && cur_last) begin
        have_previous <= 1'b0;
        first_found <= 1'b0;
        steps_used <= '0;
        set_done <= 1'b0;
      end else if (cmd.fin_plain) begin
        if (!set_done) begin
          have_previous <= 1'b1;
        end
      end else if (cmd.fin_cross) begin
        have_previous <= 1'b1;
        if (first_found) begin
          set_done <= 1'b1;
        end else begin
          first_found <= 1'b1;
        end
      end
    end
  end

endmodule

[design/sampled_zero_crossing_finder.sv]
// Top level of the sampled zero-crossing finder: controller plus datapath.
// The block takes one sample word at a time and works on it alone. A sample that
// closes no sign change is accepted and then evaluated. A sample that closes a
// strict sign change is accepted, evaluated and then refined by the bisection
// steps run on that interval (at most what is left of the set's iteration
// budget): each step walks the midpoint, distance, 32x32 multiply and compare
// stages of the datapath once. A result word is held in an output register, and
// the block only waits when a new result is due while the previous one is still
// stalled. Configuration writes are always taken.
module sampled_zero_crossing_finder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  szcf_pkg::sample_t                sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output szcf_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [szcf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [szcf_pkg::DATA_W-1:0]      cfg_data
);
  import szcf_pkg::*;

  szcf_cmd_t    cmd;
  szcf_status_t status;

  assign cfg_ready = 1'b1;

  szcf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  szcf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[design/szcf_checker.sv]
// Port-level checker for the zero-crossing finder and its bind to the top level.
module szcf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             sample_valid,
  input logic                             sample_stall,
  input logic                             result_valid,
  input logic                             result_stall,
  input szcf_pkg::result_t                result
);

  // A stalled result word keeps its valid and its value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // A word that reports no pair of crossings carries zeros.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.both_found |-> result.zero_first == '0 &&
                                           result.zero_second == '0)
    else $error("result without both crossings is not zero");

  // The block evaluates an accepted sample before it takes another one.
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample accepted in back-to-back cycles");

  // Reset leaves no result word pending.
  assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind sampled_zero_crossing_finder szcf_checker u_szcf_checker (.*);
